### rtl/hccm_pkg.sv
`default_nettype none
package hccm_pkg;

	localparam int KEYSYM_W = 29;
	localparam int BUTTON_W = 8;
	localparam int MOD_W    = 16;
	localparam int KIND_W   = 8;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 29;
	localparam int HIT_W      = 4;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_EVENT = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ESC_KEYSYM  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ESC_BUTTON  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ESC_MOD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ESC_KIND    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [MOD_W-1:0]    modfield;
		logic [BUTTON_W-1:0] button;
		logic [KEYSYM_W-1:0] keysym;
	} chord_t;

	localparam int CHORD_W = $bits(chord_t);

	typedef struct packed {
		logic tail;
		logic lock;
		logic replay;
	} flags_t;

	localparam int FLAGS_W = $bits(flags_t);

	typedef struct packed {
		logic chord_eq;
		logic kind_eq;
	} cmp_res_t;

endpackage
`default_nettype wire

### rtl/hccm_ram.sv
`default_nettype none
module hccm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/hccm_cmp.sv
`default_nettype none
module hccm_cmp (
	input  wire hccm_pkg::chord_t   chord,
	input  wire hccm_pkg::chord_t   ev,
	output hccm_pkg::cmp_res_t      res
);
	always_comb begin
		res.kind_eq  = (chord.kind == ev.kind);
		res.chord_eq = (chord.kind == ev.kind) && (chord.keysym == ev.keysym) &&
			(chord.button == ev.button) && (chord.modfield == ev.modfield);
	end
endmodule
`default_nettype wire

### rtl/hotkey_chord_chain_matcher_core.sv
`default_nettype none
// Hotkey chain matcher. Words on the slave side carry chord writes, key or button
// events and timer ticks (kind in s_tuser); each word gives exactly one result word.
// Writes, ticks and unknown kinds go straight to the result. An event walks the hotkey
// slots in order through the single read port of the chord memory, reading each
// visited slot's alternatives in turn; while a chain is open, slots with no progress
// are skipped. When an open chain dies out or the escape chord cuts a locked chain,
// the event is rescanned once. One item is processed at a time; a finished result waits
// in the output register while the next word is taken. No clearing pass after reset.
module hotkey_chord_chain_matcher_core #(
	parameter int HOTKEY_SLOTS = 16,
	parameter int CHAIN_STEPS  = 4,
	parameter int CHORD_ALTS   = 2
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// hotkey_sel, step_sel, alt_sel, key_sym, button_num, mod_mask, ev_kind,
	// replay_flag, lock_flag, tail_flag
	input  wire logic [hccm_pkg::IN_DATA_W-1:0]       s_tdata,
	// op
	input  wire logic [1:0]                           s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// matched, hit_index, replay_out, chained_out, locked_out, aborted
	output logic      [hccm_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  wire logic                                 cfg_we,
	input  wire logic [hccm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [hccm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	localparam int NROW  = HOTKEY_SLOTS * CHAIN_STEPS;
	localparam int NCH   = NROW * CHORD_ALTS;
	localparam int SW    = HOTKEY_SLOTS > 1 ? $clog2(HOTKEY_SLOTS) : 1;
	localparam int PW    = CHAIN_STEPS > 1 ? $clog2(CHAIN_STEPS) : 1;
	localparam int AW    = CHORD_ALTS > 1 ? $clog2(CHORD_ALTS) : 1;
	localparam int RW    = NROW > 1 ? $clog2(NROW) : 1;
	localparam int CW    = NCH > 1 ? $clog2(NCH) : 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SLOT   = 3'd1;
	localparam logic [2:0] ST_RD     = 3'd2;
	localparam logic [2:0] ST_ALT    = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_END    = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0] state_q;

	logic [hccm_pkg::KEYSYM_W-1:0] esc_keysym_q;
	logic [hccm_pkg::BUTTON_W-1:0] esc_button_q;
	logic [hccm_pkg::MOD_W-1:0]    esc_mod_q;
	logic [hccm_pkg::KIND_W-1:0]   esc_kind_q;
	logic [15:0]                   timeout_q;

	logic [PW-1:0]  prog_q [HOTKEY_SLOTS];
	logic           open_q;
	logic           locked_q;
	logic [15:0]    timer_q;
	logic [NCH-1:0]  chord_vld_q;
	logic [NROW-1:0] row_vld_q;

	hccm_pkg::chord_t ev_q;
	logic [SW-1:0]  slot_q;
	logic [PW-1:0]  p_q;
	logic [AW-1:0]  alt_q;
	logic           pass_q;
	logic           active_q;
	logic           hit_q;
	logic           seen_q;
	logic           kindeq_q;

	logic           res_match_q;
	logic [hccm_pkg::HIT_W-1:0] res_hit_q;
	logic           res_rep_q;
	logic           res_ab_q;
	logic           out_vld_q;
	logic [hccm_pkg::OUT_DATA_W-1:0] out_q;

	logic [1:0]              in_op;
	logic [3:0]              in_hk;
	logic [1:0]              in_step;
	logic                    in_alt;
	hccm_pkg::chord_t        in_chord;
	hccm_pkg::flags_t        in_flags;
	logic                    in_acc;
	logic                    out_load;
	logic                    wr_ok;
	logic [CW-1:0]           wr_caddr;
	logic [RW-1:0]           wr_raddr;
	logic [CW-1:0]           rd_caddr;
	logic [RW-1:0]           rd_raddr;
	logic [hccm_pkg::CHORD_W-1:0] chord_rdata;
	logic [hccm_pkg::FLAGS_W-1:0] flags_rdata;
	hccm_pkg::chord_t        rd_chord;
	hccm_pkg::flags_t        rd_flags;
	hccm_pkg::cmp_res_t      cmp_res;
	logic                    cur_vld;
	logic                    lk_new;
	logic                    is_tail;
	logic                    esc_hit;
	logic                    slot_last;
	logic [PW-1:0]           p_cur;

	assign in_op             = s_tuser;
	assign in_hk             = s_tdata[3:0];
	assign in_step           = s_tdata[5:4];
	assign in_alt            = s_tdata[6];
	assign in_chord.keysym   = s_tdata[35:7];
	assign in_chord.button   = s_tdata[43:36];
	assign in_chord.modfield = s_tdata[59:44];
	assign in_chord.kind     = s_tdata[67:60];
	assign in_flags.replay   = s_tdata[68];
	assign in_flags.lock     = s_tdata[69];
	assign in_flags.tail     = s_tdata[70];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!out_vld_q || m_tready);
	assign wr_ok    = (int'(in_hk) < HOTKEY_SLOTS) && (int'(in_step) < CHAIN_STEPS) &&
		(int'(in_alt) < CHORD_ALTS);
	assign wr_raddr = RW'(int'(in_hk) * CHAIN_STEPS + int'(in_step));
	assign wr_caddr = CW'((int'(in_hk) * CHAIN_STEPS + int'(in_step)) * CHORD_ALTS +
		int'(in_alt));
	assign rd_raddr = RW'(int'(slot_q) * CHAIN_STEPS + int'(p_q));
	assign rd_caddr = CW'((int'(slot_q) * CHAIN_STEPS + int'(p_q)) * CHORD_ALTS +
		int'(alt_q));

	hccm_ram #(.WIDTH(hccm_pkg::CHORD_W), .DEPTH(NCH)) u_chord_ram (
		.clk   (clk),
		.we    (in_acc && in_op == hccm_pkg::OP_WRITE && wr_ok),
		.waddr (wr_caddr),
		.wdata (in_chord),
		.raddr (rd_caddr),
		.rdata (chord_rdata)
	);

	hccm_ram #(.WIDTH(hccm_pkg::FLAGS_W), .DEPTH(NROW)) u_flags_ram (
		.clk   (clk),
		.we    (in_acc && in_op == hccm_pkg::OP_WRITE && wr_ok),
		.waddr (wr_raddr),
		.wdata (in_flags),
		.raddr (rd_raddr),
		.rdata (flags_rdata)
	);

	assign rd_chord = chord_rdata;

	hccm_cmp u_cmp (
		.chord (rd_chord),
		.ev    (ev_q),
		.res   (cmp_res)
	);

	always_comb begin
		rd_flags  = row_vld_q[rd_raddr] ? hccm_pkg::flags_t'(flags_rdata) : '0;
		cur_vld   = chord_vld_q[rd_caddr];
		lk_new    = locked_q | rd_flags.lock;
		is_tail   = rd_flags.tail || (p_q == PW'(CHAIN_STEPS - 1));
		slot_last = (slot_q == SW'(HOTKEY_SLOTS - 1));
		p_cur     = prog_q[slot_q];
		esc_hit   = (ev_q.kind == esc_kind_q) && (ev_q.keysym == esc_keysym_q) &&
			(ev_q.button == esc_button_q) && (ev_q.modfield == esc_mod_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			esc_keysym_q <= 29'd65307;
			esc_button_q <= '0;
			esc_mod_q    <= '0;
			esc_kind_q   <= 8'd2;
			timeout_q    <= '0;
			for (int i = 0; i < HOTKEY_SLOTS; i++) begin
				prog_q[i] <= '0;
			end
			open_q      <= 1'b0;
			locked_q    <= 1'b0;
			timer_q     <= '0;
			chord_vld_q <= '0;
			row_vld_q   <= '0;
			out_vld_q   <= 1'b0;
			out_q       <= '0;
			ev_q        <= '0;
			slot_q      <= '0;
			p_q         <= '0;
			alt_q       <= '0;
			pass_q      <= 1'b0;
			active_q    <= 1'b0;
			hit_q       <= 1'b0;
			seen_q      <= 1'b0;
			kindeq_q    <= 1'b0;
			res_match_q <= 1'b0;
			res_hit_q   <= '0;
			res_rep_q   <= 1'b0;
			res_ab_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					hccm_pkg::CFG_ESC_KEYSYM: esc_keysym_q <= cfg_data;
					hccm_pkg::CFG_ESC_BUTTON: esc_button_q <= cfg_data[7:0];
					hccm_pkg::CFG_ESC_MOD:    esc_mod_q    <= cfg_data[15:0];
					hccm_pkg::CFG_ESC_KIND:   esc_kind_q   <= cfg_data[7:0];
					hccm_pkg::CFG_TIMEOUT:    timeout_q    <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						ev_q        <= in_chord;
						res_match_q <= 1'b0;
						res_hit_q   <= '0;
						res_rep_q   <= 1'b0;
						res_ab_q    <= 1'b0;
						slot_q      <= '0;
						pass_q      <= 1'b0;
						active_q    <= 1'b0;
						priority if (in_op == hccm_pkg::OP_WRITE) begin
							state_q <= ST_DONE;
							if (wr_ok) begin
								chord_vld_q[wr_caddr] <= 1'b1;
								row_vld_q[wr_raddr]   <= 1'b1;
							end
						end else if (in_op == hccm_pkg::OP_EVENT) begin
							state_q <= ST_SLOT;
						end else if (in_op == hccm_pkg::OP_TICK) begin
							state_q <= ST_DONE;
							if (timer_q != '0) begin
								timer_q <= timer_q - 16'd1;
								if (timer_q == 16'd1) begin
									for (int i = 0; i < HOTKEY_SLOTS; i++) begin
										prog_q[i] <= '0;
									end
									open_q   <= 1'b0;
									locked_q <= 1'b0;
									res_ab_q <= 1'b1;
								end
							end
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SLOT: begin
					p_q      <= p_cur;
					alt_q    <= '0;
					hit_q    <= 1'b0;
					seen_q   <= 1'b0;
					kindeq_q <= 1'b0;
					if (open_q && p_cur == '0) begin
						if (slot_last) begin
							state_q <= ST_END;
						end else begin
							slot_q <= slot_q + SW'(1);
						end
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_ALT;
				end
				ST_ALT: begin
					if (cur_vld && !seen_q) begin
						seen_q   <= 1'b1;
						kindeq_q <= cmp_res.kind_eq;
					end
					if (cur_vld && cmp_res.chord_eq) begin
						hit_q   <= 1'b1;
						state_q <= ST_DECIDE;
					end else if (alt_q == AW'(CHORD_ALTS - 1)) begin
						state_q <= ST_DECIDE;
					end else begin
						alt_q   <= alt_q + AW'(1);
						state_q <= ST_RD;
					end
				end
				ST_DECIDE: begin
					if (hit_q && is_tail) begin
						res_rep_q   <= res_rep_q | rd_flags.replay;
						res_match_q <= 1'b1;
						res_hit_q   <= hccm_pkg::HIT_W'(slot_q);
						state_q     <= ST_DONE;
						if (open_q && !lk_new) begin
							for (int i = 0; i < HOTKEY_SLOTS; i++) begin
								prog_q[i] <= '0;
							end
							open_q   <= 1'b0;
							locked_q <= 1'b0;
							res_ab_q <= 1'b1;
							if (timeout_q != '0) begin
								timer_q <= '0;
							end
						end else begin
							locked_q <= lk_new;
						end
					end else begin
						if (slot_last) begin
							state_q <= ST_END;
						end else begin
							slot_q  <= slot_q + SW'(1);
							state_q <= ST_SLOT;
						end
						if (hit_q) begin
							res_rep_q      <= res_rep_q | rd_flags.replay;
							locked_q       <= lk_new;
							prog_q[slot_q] <= p_q + PW'(1);
							active_q       <= 1'b1;
						end else if (open_q) begin
							if (!locked_q && kindeq_q) begin
								prog_q[slot_q] <= '0;
							end else begin
								active_q <= 1'b1;
							end
						end
					end
				end
				ST_END: begin
					if (!open_q) begin
						state_q <= ST_DONE;
						if (active_q) begin
							open_q <= 1'b1;
							if (timeout_q != '0) begin
								timer_q <= timeout_q;
							end
						end
					end else if (!active_q || (locked_q && esc_hit)) begin
						for (int i = 0; i < HOTKEY_SLOTS; i++) begin
							prog_q[i] <= '0;
						end
						open_q   <= 1'b0;
						locked_q <= 1'b0;
						res_ab_q <= 1'b1;
						if (timeout_q != '0) begin
							timer_q <= '0;
						end
						if (!pass_q) begin
							pass_q   <= 1'b1;
							slot_q   <= '0;
							active_q <= 1'b0;
							state_q  <= ST_SLOT;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						state_q <= ST_DONE;
						if (timeout_q != '0) begin
							timer_q <= timeout_q;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_q     <= {7'd0, res_ab_q, locked_q, open_q, res_rep_q,
							res_hit_q, res_match_q};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

`ifndef ASSERT_OFF
	a_single_rescan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_END && pass_q) |=> (state_q != ST_SLOT))
		else $error("event rescanned more than once");
	a_alt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALT) |-> (int'(alt_q) < CHORD_ALTS))
		else $error("alternative index out of range");
	a_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[4:1] == 4'd0))
		else $error("hit index set without a match");
`endif
endmodule
`default_nettype wire

### tb/hotkey_chord_chain_matcher_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module hotkey_chord_chain_matcher_core_tb;

	localparam int SLOTS = 16;
	localparam int STEPS = 4;
	localparam int ALTS  = 2;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 322;
	localparam int SETTLE = 250;
	localparam longint LIMIT = 5000000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] slot;
		logic [1:0] step;
		logic       alt;
		hccm_pkg::chord_t ch;
		logic       replay;
		logic       lock;
		logic       tail;
	} item_t;

	typedef struct packed {
		logic       matched;
		logic [3:0] hit;
		logic       replay;
		logic       chained;
		logic       locked;
		logic       aborted;
	} match_res_t;

	typedef struct {
		item_t      it;
		bit         typed;
		match_res_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [hccm_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [hccm_pkg::OUT_DATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [hccm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [hccm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	hotkey_chord_chain_matcher_core #(
		.HOTKEY_SLOTS(SLOTS),
		.CHAIN_STEPS(STEPS),
		.CHORD_ALTS(ALTS)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hotkey table mirror
	hccm_pkg::chord_t tbl_chord [SLOTS][STEPS][ALTS];
	bit         tbl_valid [SLOTS][STEPS][ALTS];
	hccm_pkg::flags_t tbl_flags [SLOTS][STEPS];
	bit [1:0]   slot_prog [SLOTS];
	bit         chain_open, chain_locked;
	bit [15:0]  tick_count;
	hccm_pkg::chord_t esc_chord;
	bit [15:0]  timeout_val;

	match_res_t pending_results[$];
	int errors = 0;
	bit hold_req = 1'b0;
	bit stim_done = 1'b0;

	function automatic void drop_progress();
		foreach (slot_prog[s]) slot_prog[s] = '0;
		chain_open = 1'b0;
		chain_locked = 1'b0;
		if (timeout_val != 0) tick_count = '0;
	endfunction

	function automatic int scan_slots(hccm_pkg::chord_t ev, inout bit rp, inout bit ab);
		int active;
		bit hit_step, kind_eq, seen;
		bit [1:0] p;
		active = 0;
		for (int s = 0; s < SLOTS; s++) begin
			p = slot_prog[s];
			if (chain_open && p == 0) continue;
			hit_step = 1'b0;
			seen = 1'b0;
			kind_eq = 1'b0;
			for (int a = 0; a < ALTS; a++) begin
				if (tbl_valid[s][p][a]) begin
					if (tbl_chord[s][p][a] == ev) hit_step = 1'b1;
					if (!seen) kind_eq = (tbl_chord[s][p][a].kind == ev.kind);
					seen = 1'b1;
				end
			end
			if (hit_step) begin
				if (tbl_flags[s][p].replay) rp = 1'b1;
				if (tbl_flags[s][p].lock) chain_locked = 1'b1;
				if (tbl_flags[s][p].tail || p == STEPS - 1) begin
					if (chain_open && !chain_locked) begin
						drop_progress();
						ab = 1'b1;
					end
					return s;
				end
				slot_prog[s] = p + 2'd1;
				active++;
			end else if (chain_open) begin
				if (!chain_locked && kind_eq) slot_prog[s] = '0;
				else active++;
			end
		end
		if (!chain_open) begin
			if (active > 0) chain_open = 1'b1;
		end else if (active == 0 || (chain_locked && ev == esc_chord)) begin
			drop_progress();
			ab = 1'b1;
			return -2;
		end
		if (chain_open && timeout_val != 0) tick_count = timeout_val;
		return -1;
	endfunction

	function automatic match_res_t predict_match(item_t it);
		match_res_t r;
		bit rp, ab;
		int hs;
		r = '0;
		rp = 1'b0;
		ab = 1'b0;
		case (it.op)
			hccm_pkg::OP_WRITE: begin
				tbl_chord[it.slot][it.step][it.alt] = it.ch;
				tbl_valid[it.slot][it.step][it.alt] = 1'b1;
				tbl_flags[it.slot][it.step] = '{tail: it.tail, lock: it.lock, replay: it.replay};
			end
			hccm_pkg::OP_EVENT: begin
				hs = scan_slots(it.ch, rp, ab);
				if (hs == -2) hs = scan_slots(it.ch, rp, ab);
				if (hs >= 0) begin
					r.matched = 1'b1;
					r.hit = hs[3:0];
				end
			end
			hccm_pkg::OP_TICK: begin
				if (tick_count != 0) begin
					tick_count--;
					if (tick_count == 0) begin
						drop_progress();
						ab = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.replay = rp;
		r.chained = chain_open;
		r.locked = chain_locked;
		r.aborted = ab;
		return r;
	endfunction

	function automatic hccm_pkg::chord_t pool_chord(int i);
		hccm_pkg::chord_t c;
		case (i % 4)
			0: c.keysym = '0;
			1: c.keysym = 29'd1;
			2: c.keysym = 29'd65307;
			default: c.keysym = '1;
		endcase
		c.button = (i & 4) ? 8'hFF : 8'h00;
		c.modfield = (i == 5) ? 16'hFFFF : 16'h0000;
		c.kind = (((i >> 1) ^ (i >> 2)) & 1) ? 8'd3 : 8'd2;
		return c;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int pick;
		logic [95:0] rnd;
		it = '0;
		pick = $urandom_range(0, 99);
		it.slot = 4'($urandom_range(0, SLOTS - 1));
		it.step = 2'($urandom_range(0, STEPS - 1));
		it.alt = 1'($urandom_range(0, 1));
		it.replay = 1'($urandom_range(0, 1));
		it.lock = ($urandom_range(0, 4) == 0);
		it.tail = ($urandom_range(0, 2) == 0);
		rnd = {$urandom(), $urandom(), $urandom()};
		if (pick < 25) begin
			it.op = hccm_pkg::OP_WRITE;
			it.ch = pool_chord($urandom_range(0, 7));
		end else if (pick < 80) begin
			it.op = hccm_pkg::OP_EVENT;
			it.ch = pool_chord($urandom_range(0, 7));
		end else if (pick < 90) begin
			it.op = hccm_pkg::OP_TICK;
		end else if (pick < 95) begin
			it.op = hccm_pkg::OP_EVENT;
			it.ch = rnd[hccm_pkg::CHORD_W-1:0];
		end else begin
			it = rnd[$bits(item_t)-1:0];
		end
		return it;
	endfunction

	task automatic offer_word(item_t it);
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= {1'b0, it.tail, it.lock, it.replay, it.ch, it.alt, it.step, it.slot};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_match(it));
	endtask

	// keeps valid up across a burst, and after most bursts drops it for a random gap
	int burst_left = 0;
	task automatic send_paced(item_t it, bit typed, match_res_t res);
		offer_word(it);
		if (typed) begin
			void'(pending_results.pop_back());
			pending_results.push_back(res);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(hccm_pkg::chord_t esc, bit [15:0] tmo);
		logic [hccm_pkg::CFG_DATA_W-1:0] vals [5];
		logic [hccm_pkg::CFG_IDX_W-1:0] idx [5];
		vals = '{esc.keysym, hccm_pkg::CFG_DATA_W'(esc.button),
			hccm_pkg::CFG_DATA_W'(esc.modfield), hccm_pkg::CFG_DATA_W'(esc.kind),
			hccm_pkg::CFG_DATA_W'(tmo)};
		idx = '{hccm_pkg::CFG_ESC_KEYSYM, hccm_pkg::CFG_ESC_BUTTON, hccm_pkg::CFG_ESC_MOD,
			hccm_pkg::CFG_ESC_KIND, hccm_pkg::CFG_TIMEOUT};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		esc_chord = esc;
		timeout_val = tmo;
	endtask

	function automatic row_t mk_row(logic [1:0] op, int sl, int st, int al,
			hccm_pkg::chord_t ch, bit rp, bit lk, bit tl, bit typed);
		row_t r;
		r.it = '{op: op, slot: 4'(sl), step: 2'(st), alt: 1'(al), ch: ch, replay: rp,
			lock: lk, tail: tl};
		r.typed = typed;
		r.res = '0;
		return r;
	endfunction

	initial begin
		row_t rows[$];
		hccm_pkg::chord_t ch_a, ch_b, ch_x, ch_y, ch_max, ch_esc;
		ch_a = pool_chord(0);
		ch_b = pool_chord(1);
		ch_x = pool_chord(4);
		ch_y = pool_chord(6);
		ch_max = '1;
		ch_esc = '{kind: 8'd2, modfield: 16'd0, button: 8'd0, keysym: 29'd65307};
		foreach (tbl_valid[s, p, a]) tbl_valid[s][p][a] = 1'b0;
		foreach (tbl_flags[s, p]) tbl_flags[s][p] = '0;
		foreach (slot_prog[s]) slot_prog[s] = '0;
		chain_open = 1'b0;
		chain_locked = 1'b0;
		tick_count = '0;
		esc_chord = ch_esc;
		timeout_val = '0;

		// empty table, reset state and extremes
		rows.push_back(mk_row(hccm_pkg::OP_EVENT, 0, 0, 0, ch_esc, 0, 0, 0, 1));
		rows.push_back(mk_row(hccm_pkg::OP_TICK, 0, 0, 0, '0, 0, 0, 0, 1));
		rows.push_back(mk_row(OP_UNUSED, 15, 3, 1, ch_max, 1, 1, 1, 1));
		rows.push_back(mk_row(hccm_pkg::OP_WRITE, 15, 3, 1, ch_max, 1, 1, 1, 1));
		rows.push_back(mk_row(hccm_pkg::OP_WRITE, 0, 0, 0, ch_a, 1, 0, 0, 1));
		rows.push_back(mk_row(hccm_pkg::OP_WRITE, 0, 1, 1, ch_b, 0, 0, 1, 1));
		// two step chain with replay
		rows.push_back(mk_row(hccm_pkg::OP_EVENT, 0, 0, 0, ch_a, 0, 0, 0, 0));
		rows.push_back(mk_row(hccm_pkg::OP_EVENT, 0, 0, 0, ch_b, 0, 0, 0, 0));
		// mismatch of same kind resets, then abort and rescan
		rows.push_back(mk_row(hccm_pkg::OP_EVENT, 0, 0, 0, ch_a, 0, 0, 0, 0));
		rows.push_back(mk_row(hccm_pkg::OP_EVENT, 0, 0, 0, ch_y, 0, 0, 0, 0));
		rows.push_back(mk_row(hccm_pkg::OP_EVENT, 0, 0, 0, ch_a, 0, 0, 0, 0));
		rows.push_back(mk_row(hccm_pkg::OP_EVENT, 0, 0, 0, ch_a, 0, 0, 0, 0));
		// locked chain aborted by escape
		rows.push_back(mk_row(hccm_pkg::OP_WRITE, 1, 0, 0, ch_x, 0, 1, 0, 0));
		rows.push_back(mk_row(hccm_pkg::OP_WRITE, 1, 1, 0, ch_y, 0, 0, 1, 0));
		rows.push_back(mk_row(hccm_pkg::OP_EVENT, 0, 0, 0, ch_x, 0, 0, 0, 0));
		rows.push_back(mk_row(hccm_pkg::OP_EVENT, 0, 0, 0, ch_a, 0, 0, 0, 0));
		rows.push_back(mk_row(hccm_pkg::OP_EVENT, 0, 0, 0, ch_esc, 0, 0, 0, 0));
		rows.push_back(mk_row(hccm_pkg::OP_EVENT, 0, 0, 0, ch_x, 0, 0, 0, 0));
		rows.push_back(mk_row(hccm_pkg::OP_EVENT, 0, 0, 0, ch_y, 0, 0, 0, 0));
		// full length chain ending on the last step
		rows.push_back(mk_row(hccm_pkg::OP_WRITE, 15, 0, 0, ch_max, 0, 0, 0, 0));
		rows.push_back(mk_row(hccm_pkg::OP_WRITE, 15, 1, 0, ch_max, 0, 0, 0, 0));
		rows.push_back(mk_row(hccm_pkg::OP_WRITE, 15, 2, 0, ch_max, 0, 0, 0, 0));
		for (int i = 0; i < 4; i++)
			rows.push_back(mk_row(hccm_pkg::OP_EVENT, 0, 0, 0, ch_max, 0, 0, 0, 0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (rows[i]) send_paced(rows[i].it, rows[i].typed, rows[i].res);
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: ;
				1: write_regs(pool_chord(2), 16'd3);
				2: write_regs('1, 16'hFFFF);
				3: write_regs('0, 16'd0);
				4: write_regs(pool_chord(4), 16'd1);
				default: write_regs(pool_chord(6), 16'd5);
			endcase
			if (ph == 2) hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) send_paced(rand_item(), 1'b0, '0);
		end
		settle();
		stim_done = 1'b1;
	end

	// receiver stalls in stretches, with one long hold
	int rx_mode_left = 0;
	int rx_mode = 0;
	int hold_left = 0;
	bit hold_taken = 1'b0;
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= 600;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode <= $urandom_range(0, 2);
				rx_mode_left <= $urandom_range(5, 80);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		match_res_t got, want;
		if (m_tvalid && m_tready) begin
			got = '{matched: m_tdata[0], hit: m_tdata[4:1], replay: m_tdata[5],
				chained: m_tdata[6], locked: m_tdata[7], aborted: m_tdata[8]};
			if (pending_results.size() == 0) begin
				$error("result word with no expectation: %h", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.matched !== want.matched) begin
					$error("matched expected %0d got %0d", want.matched, got.matched);
					errors++;
				end
				if (got.hit !== want.hit) begin
					$error("hit_index expected %0d got %0d", want.hit, got.hit);
					errors++;
				end
				if (got.replay !== want.replay) begin
					$error("replay_out expected %0d got %0d", want.replay, got.replay);
					errors++;
				end
				if (got.chained !== want.chained) begin
					$error("chained_out expected %0d got %0d", want.chained, got.chained);
					errors++;
				end
				if (got.locked !== want.locked) begin
					$error("locked_out expected %0d got %0d", want.locked, got.locked);
					errors++;
				end
				if (got.aborted !== want.aborted) begin
					$error("aborted expected %0d got %0d", want.aborted, got.aborted);
					errors++;
				end
			end
		end
	end

	longint cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
